### src/fxalu_pkg.sv
`default_nettype none
package fxalu_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 8;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_MIN = 4'd4, OP_MAX = 4'd5, OP_EQ = 4'd6, OP_NE = 4'd7,
		OP_LT = 4'd8, OP_GT = 4'd9, OP_LE = 4'd10, OP_GE = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0] action;
		logic signed [WORD_W-1:0] operand_a;
		logic signed [WORD_W-1:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic compare_true;
		logic overflow;
		logic divide_by_zero;
	} out_item_t;

	// Item handed from the front part to the back part.
	typedef struct packed {
		op_t op;
		logic signed [WORD_W-1:0] a;
		logic signed [WORD_W-1:0] b;
		logic neg;
		logic [WORD_W-1:0] mag_a;
		logic [WORD_W-1:0] mag_b;
	} work_t;

endpackage
`default_nettype wire

### src/fxalu_front.sv
`default_nettype none
// Front part: registers accepted items and precomputes signs and magnitudes.
module fxalu_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire fxalu_pkg::in_item_t in_data,
	output logic w_valid,
	input  wire logic w_stall,
	output fxalu_pkg::work_t w_data
);
	logic v_q;
	fxalu_pkg::work_t d_q;
	fxalu_pkg::work_t nxt;

	assign in_stall = v_q && w_stall;
	assign w_valid = v_q;
	assign w_data = d_q;

	// Classify the operation and take absolute values.
	always_comb begin
		nxt.op = fxalu_pkg::op_t'(in_data.action);
		nxt.a = in_data.operand_a;
		nxt.b = in_data.operand_b;
		nxt.neg = in_data.operand_a[fxalu_pkg::WORD_W-1] ^ in_data.operand_b[fxalu_pkg::WORD_W-1];
		nxt.mag_a = in_data.operand_a[fxalu_pkg::WORD_W-1] ? -in_data.operand_a : in_data.operand_a;
		nxt.mag_b = in_data.operand_b[fxalu_pkg::WORD_W-1] ? -in_data.operand_b : in_data.operand_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!in_stall) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire

### src/fxalu_queue.sv
`default_nettype none
// Two-entry queue between the front and back parts.
module fxalu_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic i_valid,
	output logic i_stall,
	input  wire fxalu_pkg::work_t i_data,
	output logic o_valid,
	input  wire logic o_stall,
	output fxalu_pkg::work_t o_data
);
	fxalu_pkg::work_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign i_stall = (cnt_q == 2'd2);
	assign o_valid = (cnt_q != 2'd0);
	assign o_data = mem_q[rp_q];
	assign push = i_valid && !i_stall;
	assign pop = o_valid && !o_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= i_data;
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push) else $error("push into full queue");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |=> (cnt_q <= 2'd1)) else $error("queue grew by two");
endmodule
`default_nettype wire

### src/fxalu_back.sv
`default_nettype none
// Back part: pipelined execution. Stage 1 multiplies, stages 2..N divide one
// quotient bit each; the output register takes the rounded, saturated result.
module fxalu_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic w_valid,
	output logic w_stall,
	input  wire fxalu_pkg::work_t w_data,
	output logic out_valid,
	input  wire logic out_stall,
	output fxalu_pkg::out_item_t out_data
);
	localparam int W = fxalu_pkg::WORD_W;
	localparam int FRAC_BITS = fxalu_pkg::FRAC_W;
	localparam int NW = W + FRAC_BITS;      // dividend bits
	localparam int QW = NW + 1;             // quotient with one extra round bit
	localparam int ST = QW + 1;             // stages: multiply then quotient bits
	localparam int PW = 2*W - FRAC_BITS + 1; // rounded product bits
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		fxalu_pkg::op_t op;
		logic neg;
		logic signed [W-1:0] res;
		logic cmp;
		logic ovf;
		logic dz;
		logic [2*W-1:0] prod;
		logic [W:0] rem;
		logic [QW-1:0] quo;
		logic [QW-1:0] num;   // dividend shifted left by one for the round bit
		logic [W-1:0] den;
	} pipe_t;

	pipe_t p_q [ST];
	logic v_q [ST];
	logic adv;
	fxalu_pkg::out_item_t out_q;
	logic ov_q;
	fxalu_pkg::out_item_t fin;

	assign adv = !(ov_q && out_stall);
	assign w_stall = !adv;
	assign out_valid = ov_q;
	assign out_data = out_q;

	// Stage 1: simple operations finish; product formed.
	pipe_t s1;
	logic signed [W:0] sum, dif, inc, dec;
	logic signed [W-1:0] hi_int, lo_int;
	always_comb begin
		sum = {w_data.a[W-1], w_data.a} + {w_data.b[W-1], w_data.b};
		dif = {w_data.a[W-1], w_data.a} - {w_data.b[W-1], w_data.b};
		inc = {w_data.a[W-1], w_data.a} + (W+1)'(1);
		dec = {w_data.a[W-1], w_data.a} - (W+1)'(1);
		hi_int = WMAX >>> FRAC_BITS;
		lo_int = WMIN >>> FRAC_BITS;
		s1 = '0;
		s1.op = w_data.op;
		s1.neg = w_data.neg;
		s1.prod = w_data.mag_a * w_data.mag_b;
		s1.num = {{(QW-NW){1'b0}}, {w_data.mag_a, {FRAC_BITS{1'b0}}}} << 1;
		s1.den = w_data.mag_b;
		unique case (w_data.op)
			fxalu_pkg::OP_ADD: begin
				s1.ovf = sum[W] != sum[W-1];
				s1.res = s1.ovf ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];
			end
			fxalu_pkg::OP_SUB: begin
				s1.ovf = dif[W] != dif[W-1];
				s1.res = s1.ovf ? (dif[W] ? WMIN : WMAX) : dif[W-1:0];
			end
			fxalu_pkg::OP_INC: begin
				s1.ovf = inc[W] != inc[W-1];
				s1.res = s1.ovf ? WMAX : inc[W-1:0];
			end
			fxalu_pkg::OP_DEC: begin
				s1.ovf = dec[W] != dec[W-1];
				s1.res = s1.ovf ? WMIN : dec[W-1:0];
			end
			fxalu_pkg::OP_MIN: s1.res = (w_data.a < w_data.b) ? w_data.a : w_data.b;
			fxalu_pkg::OP_MAX: s1.res = (w_data.a > w_data.b) ? w_data.a : w_data.b;
			fxalu_pkg::OP_EQ: s1.cmp = w_data.a == w_data.b;
			fxalu_pkg::OP_NE: s1.cmp = w_data.a != w_data.b;
			fxalu_pkg::OP_LT: s1.cmp = w_data.a < w_data.b;
			fxalu_pkg::OP_GT: s1.cmp = w_data.a > w_data.b;
			fxalu_pkg::OP_LE: s1.cmp = w_data.a <= w_data.b;
			fxalu_pkg::OP_GE: s1.cmp = w_data.a >= w_data.b;
			fxalu_pkg::OP_FROM_INT: begin
				if (w_data.a > hi_int) begin
					s1.ovf = 1'b1;
					s1.res = WMAX;
				end else if (w_data.a < lo_int) begin
					s1.ovf = 1'b1;
					s1.res = WMIN;
				end else begin
					s1.res = w_data.a <<< FRAC_BITS;
				end
			end
			fxalu_pkg::OP_TO_INT: begin
				// Truncate toward zero: bias negatives before the shift.
				s1.res = (w_data.a + (w_data.a[W-1] ? W'((1 << FRAC_BITS) - 1) : W'(0)))
					>>> FRAC_BITS;
			end
			fxalu_pkg::OP_DIV: begin
				s1.dz = (w_data.b == '0);
				s1.res = w_data.a[W-1] ? WMIN : WMAX;
			end
			default: s1.res = '0;
		endcase
	end

	// Restoring division, one quotient bit per stage, MSB first.
	pipe_t dstep [ST];
	always_comb begin
		for (int i = 1; i < ST; i++) begin
			logic [W+1:0] trial;
			dstep[i] = p_q[i-1];
			trial = {p_q[i-1].rem, p_q[i-1].num[QW-i]} - {2'b00, p_q[i-1].den};
			if (!trial[W+1]) begin
				dstep[i].rem = trial[W:0];
				dstep[i].quo[QW-i] = 1'b1;
			end else begin
				dstep[i].rem = {p_q[i-1].rem[W-1:0], p_q[i-1].num[QW-i]};
			end
		end
		dstep[0] = s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST; i++) v_q[i] <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= w_valid;
			for (int i = 1; i < ST; i++) v_q[i] <= v_q[i-1];
			ov_q <= v_q[ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < ST; i++) p_q[i] <= dstep[i];
			out_q <= fin;
		end
	end

	// Final stage: round product or quotient, then saturate.
	logic [2*W:0] pr;
	logic [2*W-FRAC_BITS:0] pq;
	logic [QW-1:0] qr;
	logic [QW:0] mg;
	pipe_t f;
	always_comb begin
		f = p_q[ST-1];
		pr = {1'b0, f.prod} + ((2*W+1)'(1) << (FRAC_BITS - 1));
		pq = pr[2*W:FRAC_BITS];
		// Quotient carries a half bit: q+1 when remainder >= half divisor.
		qr = (f.quo >> 1) + QW'(f.quo[0]);
		mg = '0;
		fin.result_value = f.res;
		fin.compare_true = f.cmp;
		fin.overflow = f.ovf;
		fin.divide_by_zero = f.dz;
		if (f.op == fxalu_pkg::OP_MUL) begin
			mg = (QW+1)'(pq);
			if (pq > PW'({1'b1, {(W-1){1'b0}}}) - PW'(!f.neg)) begin
				fin.overflow = 1'b1;
				fin.result_value = f.neg ? WMIN : WMAX;
			end else begin
				fin.result_value = f.neg ? -pq[W-1:0] : pq[W-1:0];
			end
		end else if (f.op == fxalu_pkg::OP_DIV && !f.dz) begin
			mg = {1'b0, qr};
			if (mg > (QW+1)'({1'b1, {(W-1){1'b0}}}) - (QW+1)'(!f.neg)) begin
				fin.overflow = 1'b1;
				fin.result_value = f.neg ? WMIN : WMAX;
			end else begin
				fin.result_value = f.neg ? -qr[W-1:0] : qr[W-1:0];
			end
		end
	end

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(out_q.divide_by_zero && out_q.overflow)) else $error("dz with overflow");
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_q.compare_true |-> out_q.result_value == '0) else $error("cmp value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(out_q)) else $error("output lost");
endmodule
`default_nettype wire

### src/fixed_point_q24_8_alu.sv
`default_nettype none
// Q24.8 arithmetic unit: one item accepted per cycle when not stalled, one result
// per item. For every operation a result passes the front register, the queue,
// 42 back stages and the output register; the bit-per-stage divider pipeline sets
// that depth. Throughput is one item per cycle while the output is taken. Reset
// clears all valid flags at once; no clearing pass is needed.
module fixed_point_q24_8_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire fxalu_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output fxalu_pkg::out_item_t out_data
);
	fxalu_pkg::work_t f_data, q_data;
	logic f_valid, f_stall, q_valid, q_stall;

	fxalu_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.w_valid(f_valid), .w_stall(f_stall), .w_data(f_data)
	);

	fxalu_queue u_queue (
		.clk, .arst_n,
		.i_valid(f_valid), .i_stall(f_stall), .i_data(f_data),
		.o_valid(q_valid), .o_stall(q_stall), .o_data(q_data)
	);

	fxalu_back u_back (
		.clk, .arst_n,
		.w_valid(q_valid), .w_stall(q_stall), .w_data(q_data),
		.out_valid, .out_stall, .out_data
	);
endmodule
`default_nettype wire

### tb/sv/fixed_point_q24_8_alu_test.sv
`timescale 1ns / 100ps
`default_nettype none
module fixed_point_q24_8_alu_test;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam int LATENCY = fxalu_pkg::WORD_W + fxalu_pkg::FRAC_W + 5;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fxalu_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fxalu_pkg::out_item_t out_data;

	fxalu_pkg::in_item_t pending_q[$];
	fxalu_pkg::out_item_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit feeding_done = 1'b0;
	bit hold_sender = 1'b0;

	fixed_point_q24_8_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp a wide value to the word range, flagging saturation.
	function automatic longint sat_word(input longint v, inout bit ovf);
		if (v > Q_MAX) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		if (v < Q_MIN) begin
			ovf = 1'b1;
			return Q_MIN;
		end
		return v;
	endfunction

	// Give a sign to a magnitude and saturate.
	function automatic longint signed_mag(input bit neg, input logic [127:0] m, inout bit ovf);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (m > lim) begin
			ovf = 1'b1;
			m = lim;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	// Compute the result that the ALU should return for one item.
	function automatic fxalu_pkg::out_item_t alu_result(input fxalu_pkg::in_item_t it);
		fxalu_pkg::out_item_t r;
		longint a, b, res;
		bit ovf, cmp, dz, neg;
		logic [127:0] ma, mb, prod, num, q, rem;
		a = longint'(it.operand_a);
		b = longint'(it.operand_b);
		res = 0;
		ovf = 0;
		cmp = 0;
		dz = 0;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		case (fxalu_pkg::op_t'(it.action))
			fxalu_pkg::OP_ADD: res = sat_word(a + b, ovf);
			fxalu_pkg::OP_SUB: res = sat_word(a - b, ovf);
			fxalu_pkg::OP_MUL: begin
				prod = (ma * mb + (128'd1 << (fxalu_pkg::FRAC_W - 1))) >> fxalu_pkg::FRAC_W;
				res = signed_mag(neg, prod, ovf);
			end
			fxalu_pkg::OP_DIV: begin
				if (b == 0) begin
					dz = 1'b1;
					res = (a < 0) ? Q_MIN : Q_MAX;
				end else begin
					num = ma << fxalu_pkg::FRAC_W;
					q = num / mb;
					rem = num % mb;
					if (rem >= mb - rem) q = q + 1;
					res = signed_mag(neg, q, ovf);
				end
			end
			fxalu_pkg::OP_MIN: res = (a < b) ? a : b;
			fxalu_pkg::OP_MAX: res = (a > b) ? a : b;
			fxalu_pkg::OP_EQ: cmp = (a == b);
			fxalu_pkg::OP_NE: cmp = (a != b);
			fxalu_pkg::OP_LT: cmp = (a < b);
			fxalu_pkg::OP_GT: cmp = (a > b);
			fxalu_pkg::OP_LE: cmp = (a <= b);
			fxalu_pkg::OP_GE: cmp = (a >= b);
			fxalu_pkg::OP_INC: res = sat_word(a + 1, ovf);
			fxalu_pkg::OP_DEC: res = sat_word(a - 1, ovf);
			fxalu_pkg::OP_FROM_INT: begin
				if (a > (Q_MAX >>> fxalu_pkg::FRAC_W)) begin
					ovf = 1'b1;
					res = Q_MAX;
				end else if (a < (Q_MIN >>> fxalu_pkg::FRAC_W)) begin
					ovf = 1'b1;
					res = Q_MIN;
				end else begin
					res = a * (64'sd1 << fxalu_pkg::FRAC_W);
				end
			end
			default: res = a / (64'sd1 << fxalu_pkg::FRAC_W);
		endcase
		r.result_value = res[fxalu_pkg::WORD_W-1:0];
		r.compare_true = cmp;
		r.overflow = ovf;
		r.divide_by_zero = dz;
		return r;
	endfunction

	// Idle lengths: mostly none or short, sometimes long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random operand biased toward edges and small values.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 3)) - 32'd1;
			3: return 32'($urandom_range(0, 1023)) - 32'd512;
			4: return {{8{1'b0}}, 24'($urandom)};
			5: return 32'($urandom) >>> $urandom_range(0, 24);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input fxalu_pkg::op_t op, input logic [31:0] a,
		input logic [31:0] b);
		fxalu_pkg::in_item_t it;
		it.action = op;
		it.operand_a = a;
		it.operand_b = b;
		pending_q.push_back(it);
	endtask

	// Driver: presents queued items, holding each while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(alu_result(in_data));
			end
			if (in_valid && in_stall) begin
				// hold the stalled transfer
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (!hold_sender && pending_q.size() > 0) begin
				in_data <= pending_q.pop_front();
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stalls at random and checks each result transfer.
	always @(posedge clk) begin
		fxalu_pkg::out_item_t exp_item;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: %h", out_data);
					errors++;
				end else begin
					exp_item = expected_q.pop_front();
					if (out_data.result_value !== exp_item.result_value) begin
						$error("result_value: expected %h, got %h",
							exp_item.result_value, out_data.result_value);
						errors++;
					end
					if (out_data.compare_true !== exp_item.compare_true) begin
						$error("compare_true: expected %b, got %b",
							exp_item.compare_true, out_data.compare_true);
						errors++;
					end
					if (out_data.overflow !== exp_item.overflow) begin
						$error("overflow: expected %b, got %b",
							exp_item.overflow, out_data.overflow);
						errors++;
					end
					if (out_data.divide_by_zero !== exp_item.divide_by_zero) begin
						$error("divide_by_zero: expected %b, got %b",
							exp_item.divide_by_zero, out_data.divide_by_zero);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				recv_gap <= pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Cycle limit guards against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		fxalu_pkg::op_t op;
		// Directed items: every operation plus the edges and special cases.
		push_item(fxalu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		push_item(fxalu_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
		push_item(fxalu_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
		push_item(fxalu_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_item(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h0000_0100);
		push_item(fxalu_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080);
		push_item(fxalu_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300);
		push_item(fxalu_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
		push_item(fxalu_pkg::OP_DIV, 32'hFFFF_FF00, 32'h0000_0000);
		push_item(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
		push_item(fxalu_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
		push_item(fxalu_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(fxalu_pkg::OP_MAX, 32'h0000_0005, 32'h0000_0005);
		push_item(fxalu_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
		push_item(fxalu_pkg::OP_NE, 32'h1234_5678, 32'h1234_5679);
		push_item(fxalu_pkg::OP_LT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(fxalu_pkg::OP_GT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_item(fxalu_pkg::OP_LE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(fxalu_pkg::OP_GE, 32'h0000_0000, 32'hFFFF_FFFF);
		push_item(fxalu_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_item(fxalu_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000);
		push_item(fxalu_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0);
		push_item(fxalu_pkg::OP_FROM_INT, 32'hFF80_0000, 32'h0);
		push_item(fxalu_pkg::OP_FROM_INT, 32'hFF7F_FFFF, 32'h0);
		push_item(fxalu_pkg::OP_TO_INT, 32'hFFFF_FE80, 32'h0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// First batch drains fully before the rest is queued.
		wait (pending_q.size() == 0 && !in_valid);
		hold_sender = 1'b1;
		wait (expected_q.size() == 0);
		@(posedge clk);
		hold_sender = 1'b0;

		// Random items.
		repeat (600) begin
			op = fxalu_pkg::op_t'($urandom_range(0, 15));
			push_item(op, pick_operand(), ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand());
		end
		wait (pending_q.size() == 0 && !in_valid);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
